>>> rtl/core/jfps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi four-point sweep package
// Shared types and constants for the stencil front end, queue and back end.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COLS_W      = 7;
    localparam int unsigned ROWS_W      = 16;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // Register select, taken from address bit 2.
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // One request that produces results: the operands of the stencil and
    // the flags that say what to emit.
    typedef struct packed {
        logic signed [DATA_W-1:0] in_val;
        logic signed [DATA_W-1:0] mid_c;
        logic signed [DATA_W-1:0] mid_r;
        logic signed [DATA_W-1:0] up_c;
        logic signed [DATA_W-1:0] up_l;
        logic                     border;
        logic                     emit_up;
        logic                     emit_self;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/jfps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jfps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/jfps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi sweep front end
// Accepts cells, tracks the raster position, keeps the two row buffers and
// gathers the stencil operands of each cell that produces results.
// ----------------------------------------------------------------------------
module jfps_front #(
    parameter int unsigned MAX_COLS = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [jfps_pkg::COLS_W-1:0]          cols_in_use,
    input  wire logic [jfps_pkg::ROWS_W-1:0]          rows_in_use,
    input  wire logic                                 restart,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic signed [jfps_pkg::DATA_W-1:0]   s_tdata,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output jfps_pkg::entry_t                          q_entry
);

    localparam int unsigned IDX_W = $clog2(MAX_COLS);
    localparam int unsigned CNT_W = $clog2(MAX_COLS + 1);

    logic [IDX_W-1:0]                  col_reg, col_next, col_next_p1;
    logic [jfps_pkg::ROWS_W-1:0]       row_reg, row_next;
    logic [jfps_pkg::DATA_W-1:0]       left_reg, left_next;
    logic [CNT_W-1:0]                  cols_eff;
    logic [jfps_pkg::ROWS_W-1:0]       rows_eff;
    logic                              accept, last_col, final_row;
    logic [jfps_pkg::DATA_W-1:0]       rd_mid_c, rd_mid_r, rd_up;

    always_comb begin
        if (32'(cols_in_use) < 32'd3) begin
            cols_eff = CNT_W'(3);
        end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
            cols_eff = CNT_W'(MAX_COLS);
        end else begin
            cols_eff = CNT_W'(cols_in_use);
        end
        rows_eff = (rows_in_use < 16'd3) ? 16'd3 : rows_in_use;
    end

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign last_col  = (col_reg == IDX_W'(cols_eff - CNT_W'(1)));
    assign final_row = (row_reg == (rows_eff - 16'd1));

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        left_next = left_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            left_next = rd_mid_c;
            if (last_col) begin
                col_next = '0;
                row_next = final_row ? '0 : row_reg + 16'd1;
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
        if (col_next == IDX_W'(MAX_COLS - 1)) begin
            col_next_p1 = '0;
        end else begin
            col_next_p1 = col_next + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        left_reg <= left_next;
    end

    jfps_ram #(.WIDTH(jfps_pkg::DATA_W), .DEPTH(MAX_COLS)) u_mid_c (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_tdata),
        .raddr (col_next),
        .rdata (rd_mid_c)
    );

    jfps_ram #(.WIDTH(jfps_pkg::DATA_W), .DEPTH(MAX_COLS)) u_mid_r (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_tdata),
        .raddr (col_next_p1),
        .rdata (rd_mid_r)
    );

    jfps_ram #(.WIDTH(jfps_pkg::DATA_W), .DEPTH(MAX_COLS)) u_up (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (rd_mid_c),
        .raddr (col_next),
        .rdata (rd_up)
    );

    assign q_push = accept && (row_reg != '0);

    always_comb begin
        q_entry.in_val    = s_tdata;
        q_entry.mid_c     = rd_mid_c;
        q_entry.mid_r     = rd_mid_r;
        q_entry.up_c      = rd_up;
        q_entry.up_l      = left_reg;
        q_entry.border    = (row_reg == 16'd1) || (col_reg == '0) || last_col;
        q_entry.emit_up   = (row_reg != '0);
        q_entry.emit_self = final_row;
    end

`ifndef NO_ASSERTIONS
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame position not cleared after register write");
`endif

endmodule

`default_nettype wire

>>> rtl/core/jfps_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi sweep request queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module jfps_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire jfps_pkg::entry_t push_entry,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output jfps_pkg::entry_t      head
);

    jfps_pkg::entry_t                 slot_reg [jfps_pkg::QUEUE_DEPTH];
    logic [jfps_pkg::QPTR_W-1:0]      wr_reg, wr_next, rd_reg, rd_next;
    logic [jfps_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign full       = (cnt_reg == jfps_pkg::QCNT_W'(jfps_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + jfps_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = pop ? rd_reg + jfps_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + jfps_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - jfps_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("request pushed into a full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("request popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/jfps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi sweep back end
// Forms the averaged or border value of each request and drives the result
// register, emitting the final-row cell itself as a second result.
// ----------------------------------------------------------------------------
module jfps_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 head_valid,
    input  wire jfps_pkg::entry_t                     head,
    output logic                                      pop,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic signed [jfps_pkg::DATA_W-1:0]        m_tdata
);

    logic                                 phase_reg, phase_next;
    logic                                 valid_reg, valid_next;
    logic signed [jfps_pkg::DATA_W-1:0]   data_reg, data_next;
    logic signed [jfps_pkg::DATA_W+1:0]   sum;
    logic signed [jfps_pkg::DATA_W-1:0]   upper_value;
    logic                                 load;

    always_comb begin
        sum = {{2{head.up_l[jfps_pkg::DATA_W-1]}}, head.up_l}
            + {{2{head.mid_r[jfps_pkg::DATA_W-1]}}, head.mid_r}
            + {{2{head.up_c[jfps_pkg::DATA_W-1]}}, head.up_c}
            + {{2{head.in_val[jfps_pkg::DATA_W-1]}}, head.in_val};
        upper_value = head.border ? head.mid_c : sum[jfps_pkg::DATA_W+1:2];
    end

    assign load = !valid_reg || m_tready;

    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (head.emit_up && !phase_reg) begin
                    data_next = upper_value;
                    if (head.emit_self) begin
                        phase_next = 1'b1;
                    end else begin
                        pop = 1'b1;
                    end
                end else begin
                    data_next  = head.in_val;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef NO_ASSERTIONS
    a_phase_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> head_valid && head.emit_self)
        else $error("second result pending without a final-row request");
    a_pop_needs_load: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid)
        else $error("request retired without a result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/jacobi_four_point_sweep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi four-point sweep
// One Jacobi sweep of the five-point stencil over a raster stream of signed
// Q16.16 grid cells, with an APB register port for the grid size.
// ----------------------------------------------------------------------------
// The block takes one cell per clock while its request queue has room and
// gives each cell of the previous row out as the next row arrives: interior
// cells as the floored mean of their four neighbors, border cells unchanged.
// A cell of the final row gives two results (the cell above it, then itself),
// so while the final row streams the result port paces the input. The result
// of a cell passes through the request queue and then the output register.
// The row buffers are three one-read-port RAMs of MAX_COLS words read at the
// next raster position; they need no clearing after reset.
// Writing either register restarts the frame at row zero, column zero.
// ----------------------------------------------------------------------------
module jacobi_four_point_sweep #(
    parameter int unsigned MAX_COLS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // s_tdata: [31:0] in_value
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic signed [jfps_pkg::DATA_W-1:0]     s_tdata,
    // m_tdata: [31:0] out_value
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic signed [jfps_pkg::DATA_W-1:0]          m_tdata,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [jfps_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire logic [jfps_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [jfps_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                        pready
);

    logic [jfps_pkg::COLS_W-1:0]  cols_reg, cols_next;
    logic [jfps_pkg::ROWS_W-1:0]  rows_reg, rows_next;
    logic                         cfg_write;
    logic                         q_full, q_push, q_pop, q_head_valid;
    jfps_pkg::entry_t             q_entry, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                jfps_pkg::REG_COLS: cols_next = pwdata[jfps_pkg::COLS_W-1:0];
                jfps_pkg::REG_ROWS: rows_next = pwdata[jfps_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            jfps_pkg::REG_COLS: prdata = jfps_pkg::APB_DATA_W'(cols_reg);
            jfps_pkg::REG_ROWS: prdata = jfps_pkg::APB_DATA_W'(rows_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 7'd12;
            rows_reg <= 16'd12;
        end else begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    jfps_front #(.MAX_COLS(MAX_COLS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cols_in_use (cols_reg),
        .rows_in_use (rows_reg),
        .restart     (cfg_write),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    jfps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    jfps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

>>> tb/jfps_sweep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi four-point sweep checker
// Watches the register port and both streams of the sweep block, keeps its
// own copy of the row buffers, counters and grid size, and works out the
// cells that each accepted request must produce. Every result is compared
// with the oldest cell still outstanding.
// ----------------------------------------------------------------------------
module jfps_sweep_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               pending,
    output int               errors
);

    localparam int LINE_CELLS = 64;

    logic [31:0] upper_row [0:LINE_CELLS-1];
    logic [31:0] mid_row   [0:LINE_CELLS-1];
    logic [6:0]  cols_reg;
    logic [15:0] rows_reg;
    int          row_pos;
    int          col_pos;
    logic [31:0] expected_cells [$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [33:0] widen(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    task automatic sweep_cell(input logic [31:0] in_val);
        int          ncols;
        int          nrows;
        int          c;
        int          r;
        logic [33:0] sum;
        logic [31:0] v;
        ncols = (cols_reg < 3) ? 3 : (cols_reg > LINE_CELLS) ? LINE_CELLS : int'(cols_reg);
        nrows = (rows_reg < 3) ? 3 : int'(rows_reg);
        if (col_pos >= ncols) col_pos = 0;
        if (row_pos >= nrows) row_pos = 0;
        c = col_pos;
        r = row_pos;
        if (r >= 1) begin
            if (r == 1 || c == 0 || c == ncols - 1) begin
                v = mid_row[c];
            end else begin
                // The left neighbor has already moved into the upper buffer.
                sum = widen(upper_row[c-1]) + widen(mid_row[c+1])
                    + widen(upper_row[c]) + widen(in_val);
                v = sum[33:2];
            end
            expected_cells.push_back(v);
        end
        if (r == nrows - 1) begin
            expected_cells.push_back(in_val);
        end
        upper_row[c] = mid_row[c];
        mid_row[c] = in_val;
        if (c + 1 >= ncols) begin
            col_pos = 0;
            row_pos = (r + 1 >= nrows) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            for (int i = 0; i < LINE_CELLS; i++) begin
                upper_row[i] = '0;
                mid_row[i] = '0;
            end
            cols_reg = 7'd12;
            rows_reg = 16'd12;
            row_pos = 0;
            col_pos = 0;
            expected_cells.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == jfps_pkg::REG_COLS) begin
                    cols_reg = pwdata[6:0];
                end else begin
                    rows_reg = pwdata[15:0];
                end
                row_pos = 0;
                col_pos = 0;
            end
            if (s_tvalid && s_tready) begin
                sweep_cell(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request waiting", m_tdata));
                end else begin
                    want = expected_cells.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("out_value %h, expected %h", m_tdata, want));
                    end
                end
            end
        end
        pending = expected_cells.size();
    end

endmodule

>>> tb/tb_jacobi_four_point_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jacobi four-point sweep testbench
// Drives grid frames of Q16.16 cells into the sweep block under a range of
// grid sizes, with random gaps on the input and random stalls on the output,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_jacobi_four_point_sweep;

    localparam int          ITEM_TARGET = 1650;
    localparam int          SETTLE      = 10;
    localparam logic [31:0] CELL_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] CELL_MIN    = 32'h8000_0000;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic signed [jfps_pkg::DATA_W-1:0]  s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic signed [jfps_pkg::DATA_W-1:0]  m_tdata;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [jfps_pkg::APB_ADDR_W-1:0]     paddr;
    logic [jfps_pkg::APB_DATA_W-1:0]     pwdata;
    logic [jfps_pkg::APB_DATA_W-1:0]     prdata;
    logic                                pready;

    int          pending;
    int          errors;
    int          sent;
    bit          gaps_on;
    bit          stall_on;
    bit          quiet_tail;
    logic [6:0]  cols_val;
    logic [15:0] rows_val;

    jacobi_four_point_sweep dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    jfps_sweep_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pending  (pending),
        .errors   (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else if (stall_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                hold = $urandom_range(0, 5);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Stops the input and waits until every outstanding result has left, then
    // idles for the SETTLE period for cells of the first row still in the pipeline.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        quiesce();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {sel, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (sel == jfps_pkg::REG_COLS) begin
            cols_val = value[6:0];
        end else begin
            rows_val = value[15:0];
        end
    endtask

    task automatic send_cell(input logic [31:0] v);
        int gap;
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    function automatic logic [31:0] random_cell();
        case ($urandom_range(0, 7))
            0: return CELL_MAX;
            1: return CELL_MIN;
            2: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_cols();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2);
            1: return 64;
            2: return $urandom_range(65, 127);
            3: return 3;
            default: return $urandom_range(3, 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_rows();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2);
            1: return 65535;
            2: return 3;
            default: return $urandom_range(3, 8);
        endcase
    endfunction

    task automatic run_cells(input int count);
        repeat (count) begin
            send_cell(random_cell());
            if ($urandom_range(0, 299) == 0) quiesce();
        end
    endtask

    initial begin
        logic [31:0] tall_grid [0:11];
        logic [31:0] square_grid [0:8];
        int ncols;
        int nrows;
        int count;
        int pick;

        tall_grid = '{32'h0000_0000, CELL_MAX, 32'hFFFF_FFFF,
                      CELL_MAX, CELL_MIN, CELL_MAX,
                      CELL_MIN, CELL_MAX, CELL_MIN,
                      32'h0000_0001, CELL_MIN, CELL_MAX};
        square_grid = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'h0000_0000, 32'h0000_0005, 32'h0000_0000,
                        32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        gaps_on = 1'b0;
        stall_on = 1'b0;
        quiet_tail = 1'b0;
        cols_val = 7'd12;
        rows_val = 16'd12;
        aresetn = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Interior sums at both extremes, then a negative sum that must floor.
        gaps_on = 1'b1;
        stall_on = 1'b1;
        write_reg(jfps_pkg::REG_COLS, 3);
        write_reg(jfps_pkg::REG_ROWS, 4);
        for (int i = 0; i < 12; i++) begin
            send_cell(tall_grid[i]);
            if (i == 5) quiesce();
        end
        write_reg(jfps_pkg::REG_ROWS, 3);
        for (int i = 0; i < 9; i++) send_cell(square_grid[i]);

        // Size limits: widest row, longest frame, and counts below the minimum.
        write_reg(jfps_pkg::REG_COLS, 64);
        run_cells(64 * 3);
        write_reg(jfps_pkg::REG_COLS, 127);
        write_reg(jfps_pkg::REG_ROWS, 65535);
        run_cells($urandom_range(70, 200));
        write_reg(jfps_pkg::REG_COLS, 0);
        write_reg(jfps_pkg::REG_ROWS, 0);
        run_cells(9 * 2);

        while (sent < ITEM_TARGET - 120) begin
            gaps_on = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 2);
                if (pick != 1) write_reg(jfps_pkg::REG_COLS, pick_cols());
                if (pick != 0) write_reg(jfps_pkg::REG_ROWS, pick_rows());
            end
            ncols = (cols_val < 3) ? 3 : (cols_val > 64) ? 64 : int'(cols_val);
            nrows = (rows_val < 3) ? 3 : int'(rows_val);
            if (ncols * nrows > 300) begin
                count = $urandom_range(1, 4 * ncols);
            end else begin
                count = ncols * nrows * $urandom_range(1, 3);
                if ($urandom_range(0, 5) == 0) begin
                    count = count - $urandom_range(1, ncols * nrows - 1);
                end
            end
            if (count > ITEM_TARGET - 120 - sent) begin
                count = ITEM_TARGET - 120 - sent;
            end
            run_cells(count);
        end

        quiet_tail = 1'b1;
        write_reg(jfps_pkg::REG_COLS, $urandom_range(3, 16));
        write_reg(jfps_pkg::REG_ROWS, $urandom_range(4, 8));
        run_cells(2 * int'(cols_val) * int'(rows_val));

        quiesce();
        repeat (20) @(negedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
